/* src/vcrd_pkg.sv */
// Package for the vector clock race detector: sizes, request and state codes, vector type and helpers.
// No dependencies; used by vector_clock_race_detector_unit (vcrd_ram does not import it).
package vcrd_pkg;
  localparam int ThreadCount   = 8;
  localparam int VariableCount = 256;
  localparam int LockCount     = 64;
  localparam int SignalCount   = 64;
  localparam int AtomicCount   = 64;
  localparam int ClockBits     = 32;
  localparam int TidBits       = 3;
  localparam int ObjBits       = 8;
  // object store: read hist, write hist, lock, signal, atomic regions
  localparam int ObjDepth = 2 * VariableCount + LockCount + SignalCount + AtomicCount;
  localparam int ObjAddrBits = $clog2(ObjDepth);
  localparam int RdBase  = 0;
  localparam int WrBase  = VariableCount;
  localparam int LkBase  = 2 * VariableCount;
  localparam int SgBase  = LkBase + LockCount;
  localparam int AtBase  = SgBase + SignalCount;
  localparam int ClearCycles = ObjDepth;

  typedef logic [ClockBits-1:0] entry_t;
  typedef entry_t [ThreadCount-1:0] vclock_t;

  typedef enum logic [2:0] {
    REQ_READ   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_LOCK   = 3'd2,
    REQ_UNLOCK = 3'd3,
    REQ_SIGNAL = 3'd4,
    REQ_WAIT   = 3'd5,
    REQ_ATOMIC = 3'd6,
    REQ_NONE   = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_t;

  function automatic vclock_t vc_max(vclock_t a, vclock_t b);
    vclock_t r;
    for (int i = 0; i < ThreadCount; i++) r[i] = (a[i] > b[i]) ? a[i] : b[i];
    return r;
  endfunction

  function automatic logic vc_leq(vclock_t a, vclock_t b);
    logic r;
    r = 1'b1;
    for (int i = 0; i < ThreadCount; i++) if (a[i] > b[i]) r = 1'b0;
    return r;
  endfunction
endpackage

/* src/vector_clock_race_detector_unit.sv */
// Top level of the vector clock race detector: stream ports, sequencer, two RAMs.
// Depends on vcrd_pkg and vcrd_ram.
// Each word passes ST_READ and ST_WRITE before its result word is registered; a read or
// write passes both states twice, reading both variable histories through the one read port.
// A new word is taken in the cycle after the result is taken, so the unit holds one event
// at a time. After reset a clearing pass over all ObjDepth (704) entries zeroes the object
// store; thread clocks clear during the same pass.
module vector_clock_race_detector_unit
  import vcrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // req_type[2:0], thread_id[5:3], object_id[13:6], source_ref[45:14]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // race_with_write[0], race_with_read[1], report_ref[33:2]
);
  state_t state, state_next;
  logic [ObjAddrBits-1:0] clr_cnt;
  logic [2:0] kind;
  logic [TidBits-1:0] tid;
  logic [ObjBits-1:0] obj;
  logic [31:0] src;
  logic valid_op;
  logic [ObjAddrBits-1:0] oaddr;
  logic rw, rr;
  logic out_valid;
  logic out_rw, out_rr;
  logic [31:0] out_ref;
  logic hist_phase;
  logic race_hold;
  logic first_phase;

  logic t_we, o_we;
  logic [TidBits-1:0] t_waddr;
  logic [ObjAddrBits-1:0] o_waddr;
  vclock_t t_wdata, t_rdata, o_wdata, o_rdata;
  logic [2:0] in_kind;
  logic [TidBits-1:0] in_tid;
  logic [ObjBits-1:0] in_obj;
  logic in_ok;
  logic [ObjAddrBits-1:0] in_addr;

  vcrd_ram #(.Width(ThreadCount*ClockBits), .Depth(ThreadCount)) u_thread (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(tid), .rdata(t_rdata));
  vcrd_ram #(.Width(ThreadCount*ClockBits), .Depth(ObjDepth)) u_object (
    .clk, .we(o_we), .waddr(o_waddr), .wdata(o_wdata), .raddr(oaddr), .rdata(o_rdata));

  assign in_kind = s_tdata[2:0];
  assign in_tid  = s_tdata[5:3];
  assign in_obj  = s_tdata[13:6];

  // reads check the write history first, writes the read history
  always_comb begin
    in_ok = 1'b1;
    in_addr = '0;
    unique case (req_t'(in_kind))
      REQ_READ: in_addr = ObjAddrBits'(WrBase + 32'(in_obj));
      REQ_WRITE: in_addr = ObjAddrBits'(RdBase + 32'(in_obj));
      REQ_LOCK, REQ_UNLOCK: begin
        in_ok = 32'(in_obj) < LockCount;
        in_addr = ObjAddrBits'(LkBase + 32'(in_obj));
      end
      REQ_SIGNAL, REQ_WAIT: begin
        in_ok = 32'(in_obj) < SignalCount;
        in_addr = ObjAddrBits'(SgBase + 32'(in_obj));
      end
      REQ_ATOMIC: begin
        in_ok = 32'(in_obj) < AtomicCount;
        in_addr = ObjAddrBits'(AtBase + 32'(in_obj));
      end
      default: in_ok = 1'b0;
    endcase
  end

  assign s_tready = (state == ST_IDLE) && !out_valid;

  assign first_phase = (state == ST_WRITE) && valid_op && !hist_phase &&
                       ((req_t'(kind) == REQ_READ) || (req_t'(kind) == REQ_WRITE));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (32'(clr_cnt) == ClearCycles - 1) state_next = ST_IDLE;
      ST_IDLE:  if (s_tvalid && s_tready) state_next = ST_READ;
      ST_READ:  state_next = ST_WRITE;
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  vclock_t tc, joined, tc_new;
  always_comb begin
    tc = t_rdata;
    if (tc[tid] == '0) tc[tid] = entry_t'(1);
    joined = vc_max(tc, o_rdata);
    rw = 1'b0;
    rr = 1'b0;
    t_we = 1'b0;
    o_we = 1'b0;
    t_wdata = tc;
    o_wdata = joined;
    t_waddr = tid;
    o_waddr = oaddr;
    tc_new = tc;
    unique case (state)
      ST_CLEAR: begin
        o_we = 1'b1;
        o_waddr = clr_cnt;
        o_wdata = '0;
        t_we = 32'(clr_cnt) < ThreadCount;
        t_waddr = clr_cnt[TidBits-1:0];
        t_wdata = '0;
      end
      ST_WRITE: begin
        if (valid_op && !first_phase) begin
          unique case (req_t'(kind))
            REQ_READ: rw = race_hold;
            REQ_WRITE: begin
              rw = !vc_leq(o_rdata, tc);
              rr = race_hold;
            end
            REQ_LOCK, REQ_WAIT, REQ_ATOMIC: tc_new = joined;
            default: ;
          endcase
          o_we = (req_t'(kind) != REQ_LOCK) && (req_t'(kind) != REQ_WAIT);
          if (req_t'(kind) == REQ_SIGNAL) o_wdata = tc;
          if (tc_new[tid] != '1) tc_new[tid] = tc_new[tid] + entry_t'(1);
          t_we = 1'b1;
          t_wdata = tc_new;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      hist_phase <= 1'b0;
    end else begin
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (m_tvalid && m_tready) out_valid <= 1'b0;
      if (state == ST_IDLE && s_tvalid && s_tready) begin
        kind <= in_kind;
        tid <= in_tid;
        obj <= in_obj;
        src <= s_tdata[45:14];
        valid_op <= in_ok;
        oaddr <= in_addr;
        hist_phase <= 1'b0;
      end
      // hold the first check, then read the history to merge into
      if (first_phase) begin
        race_hold <= !vc_leq(o_rdata, tc);
        oaddr <= (req_t'(kind) == REQ_READ) ? ObjAddrBits'(RdBase + 32'(obj)) :
                 ObjAddrBits'(WrBase + 32'(obj));
        hist_phase <= 1'b1;
        state <= ST_READ;
      end else begin
        state <= state_next;
        if (state == ST_WRITE) begin
          out_valid <= 1'b1;
          out_rw <= rw;
          out_rr <= rr;
          out_ref <= src;
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_ref, out_rr, out_rw};
endmodule

/* src/vcrd_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module vcrd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrBits = $clog2(Depth)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrBits-1:0] waddr,
  input  logic [Width-1:0]    wdata,
  input  logic [AddrBits-1:0] raddr,
  output logic [Width-1:0]    rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
